>>> rtl/sps_pkg.sv
// Shared widths, register indexes, types and constants for the stereogram pixel shifter.
package sps_pkg;

  localparam int LW_W      = 11;
  localparam int REP_W     = 6;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int SUM_W     = 10;
  localparam int OFS_W     = 6;

  localparam int DEF_MAX_LINE_WIDTH = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPETITIONS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_DEPTH = 2'd2;

  localparam logic [LW_W-1:0]  RST_LINE_WIDTH  = 11'd800;
  localparam logic [REP_W-1:0] RST_REPETITIONS = 6'd10;

  // grey = sum / 3 as (sum * 683) >> 11, exact for sum < 2048
  localparam int GREY_MUL   = 683;
  localparam int GREY_SHIFT = 11;

  // step = 255 / reps; offset = (grey * ceil(2^16 / step)) >> 16
  localparam int STEP_NUM    = 255;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 15;
  localparam int RECIP_BIAS  = (1 << RECIP_SHIFT) - 1;

  localparam int DIV_NW = 17;
  localparam int DIV_DW = 8;

  typedef struct packed {
    logic [LW_W-1:0]    width;
    logic [LW_W-1:0]    strip;
    logic [RECIP_W-1:0] recip;
    logic               invert;
    logic               ready;
  } sps_params_t;

  typedef enum logic [2:0] {
    P_START,
    P_STRIP,
    P_STEP,
    P_RECIP,
    P_IDLE
  } sps_pstate_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GREY,
    S_OFS,
    S_ADDR,
    S_DATA
  } sps_state_t;

endpackage

>>> rtl/stereogram_pixel_shifter.sv
// Stereogram pixel shifter top level: line store, depth offset datapath and output register.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------------------
//  s_*      | in        | s_tvalid / s_tready        | s_tdata: depth r,g,b, pattern r,g,b
//  m_*      | out       | m_tvalid / m_tready        | m_tdata: out r,g,b; m_tlast: end of line
//  cfg_*    | in        | cfg_we                     | cfg_index, cfg_data
//
// Each item passes in turn through accept, grey multiply, offset multiply, line store read and write back.
// The line store (one read, one write port) is read and written once per item.
// After reset and after a line_width or repetitions write, the strip width and depth
// reciprocal are recomputed by a shared serial divider; s_tready is low until that is done.
// Reset is synchronous; the line store is not cleared. A new item is accepted while a result
// waits in the output register; a stalled m_tready holds the write-back step.
module stereogram_pixel_shifter #(
  parameter int MAX_LINE_WIDTH = sps_pkg::DEF_MAX_LINE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [47:0]                  s_tdata,   // depth_red, depth_green, depth_blue,
                                                  // pattern_red, pattern_green, pattern_blue
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,   // out_red, out_green, out_blue
  output logic                         m_tlast,   // end_of_line
  input  logic                         cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sps_pkg::CFG_W-1:0]     cfg_data
);
  import sps_pkg::*;

  localparam int AW  = $clog2(MAX_LINE_WIDTH);
  localparam int XW  = ((AW > LW_W) ? AW : LW_W) + 1;
  localparam int SXW = XW + 1;

  sps_params_t prm;

  sps_params #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_params (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .prm       (prm)
  );

  sps_state_t state, state_next;

  logic [AW-1:0]    col;
  logic [SUM_W-1:0] sum;
  logic [PIX_W-1:0] pattern;
  logic [CH_W-1:0]  grey;
  logic [OFS_W-1:0] offset;
  logic             black;
  logic             use_pattern;
  logic [PIX_W-1:0] rdata;
  logic [PIX_W-1:0] mem [MAX_LINE_WIDTH];

  logic                    accept;
  logic                    out_load;
  logic [2*SUM_W-1:0]      grey_prod;
  logic [CH_W+RECIP_W-1:0] ofs_prod;
  logic signed [SXW-1:0]   rd_base;
  logic signed [SXW-1:0]   rd;
  logic                    rd_black;
  logic                    in_strip;
  logic [PIX_W-1:0]        pix;
  logic [XW-1:0]           col_inc;
  logic                    eol;

  assign s_tready = (state == S_IDLE) && prm.ready;
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == S_DATA) && (!m_tvalid || m_tready);

  always_comb begin
    grey_prod = (2*SUM_W)'(sum) * (2*SUM_W)'(GREY_MUL);
    ofs_prod  = (CH_W+RECIP_W)'(grey) * (CH_W+RECIP_W)'(prm.recip);
    rd_base   = signed'(SXW'(col)) - signed'(SXW'(prm.strip));
    rd        = prm.invert ? rd_base - signed'(SXW'(offset))
                           : rd_base + signed'(SXW'(offset));
    rd_black  = (rd < 0) || (rd >= signed'(SXW'(prm.width)));
    in_strip  = XW'(col) < XW'(prm.strip);
    pix       = use_pattern ? pattern : (black ? '0 : rdata);
    col_inc   = XW'(col) + XW'(1);
    eol       = col_inc >= XW'(prm.width);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_GREY;
      S_GREY: state_next = S_OFS;
      S_OFS:  state_next = S_ADDR;
      S_ADDR: state_next = S_DATA;
      S_DATA: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      col      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
        col      <= eol ? '0 : col_inc[AW-1:0];
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum     <= SUM_W'(s_tdata[7:0]) + SUM_W'(s_tdata[15:8]) + SUM_W'(s_tdata[23:16]);
      pattern <= s_tdata[47:24];
    end
    if (state == S_GREY) begin
      grey <= grey_prod[GREY_SHIFT +: CH_W];
    end
    if (state == S_OFS) begin
      offset <= ofs_prod[RECIP_SHIFT +: OFS_W];
    end
    if (state == S_ADDR) begin
      black       <= rd_black;
      use_pattern <= in_strip;
    end
    if (out_load) begin
      m_tdata <= pix;
      m_tlast <= eol;
    end
  end

  // line store: read in the address step, written back with the result
  always_ff @(posedge clk) begin
    if (state == S_ADDR) begin
      rdata <= mem[rd[AW-1:0]];
    end
    if (out_load) begin
      mem[col] <= pix;
    end
  end

endmodule

>>> rtl/sps_div.sv
// Restoring divider, one quotient bit per cycle.
module sps_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sps_pkg::DIV_NW-1:0] dividend,
  input  logic [sps_pkg::DIV_DW-1:0] divisor,
  output logic                      done,
  output logic [sps_pkg::DIV_NW-1:0] quotient
);
  import sps_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_NW-1:0] quot;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   diff;
  logic              ge;

  always_comb begin
    rem_sh = {rem, quot[DIV_NW-1]};
    ge     = rem_sh >= {1'b0, dsr};
    diff   = rem_sh - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      quot <= {quot[DIV_NW-2:0], ge};
      rem  <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
    end
  end

  assign quotient = quot;

endmodule

>>> rtl/sps_params.sv
// Configuration registers and derived strip width and depth reciprocal.
module sps_params #(
  parameter int MAX_LINE_WIDTH = sps_pkg::DEF_MAX_LINE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sps_pkg::CFG_W-1:0]     cfg_data,
  output sps_pkg::sps_params_t         prm
);
  import sps_pkg::*;

  logic [LW_W-1:0]    line_width;
  logic [REP_W-1:0]   repetitions;
  logic               invert_depth;
  logic [LW_W-1:0]    strip;
  logic [RECIP_W-1:0] recip;
  sps_pstate_t        state, state_next;

  logic [LW_W-1:0]    eff_w;
  logic [REP_W-1:0]   eff_reps;
  logic               div_start;
  logic [DIV_NW-1:0]  div_a;
  logic [DIV_DW-1:0]  div_b;
  logic               div_done;
  logic [DIV_NW-1:0]  div_q;
  logic               restart;

  always_comb begin
    if (line_width == '0) begin
      eff_w = LW_W'(1);
    end else if (32'(line_width) > MAX_LINE_WIDTH) begin
      eff_w = LW_W'(MAX_LINE_WIDTH);
    end else begin
      eff_w = line_width;
    end
    eff_reps = (repetitions == '0) ? REP_W'(1) : repetitions;
  end

  assign restart = cfg_we && (cfg_index == REG_LINE_WIDTH || cfg_index == REG_REPETITIONS);

  sps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_a      = DIV_NW'(eff_w);
    div_b      = DIV_DW'(eff_reps);
    unique case (state)
      P_START: begin
        div_start  = 1'b1;
        state_next = P_STRIP;
      end
      P_STRIP: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_a      = DIV_NW'(STEP_NUM);
          state_next = P_STEP;
        end
      end
      P_STEP: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_a      = DIV_NW'(RECIP_BIAS) + DIV_NW'(div_q[DIV_DW-1:0]);
          div_b      = div_q[DIV_DW-1:0];
          state_next = P_RECIP;
        end
      end
      P_RECIP: begin
        if (div_done) begin
          state_next = P_IDLE;
        end
      end
      P_IDLE: begin
        state_next = P_IDLE;
      end
      default: begin
        state_next = P_START;
      end
    endcase
    if (restart) begin
      div_start  = 1'b0;
      state_next = P_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= P_START;
      line_width   <= RST_LINE_WIDTH;
      repetitions  <= RST_REPETITIONS;
      invert_depth <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LINE_WIDTH:   line_width   <= cfg_data[LW_W-1:0];
          REG_REPETITIONS:  repetitions  <= cfg_data[REP_W-1:0];
          REG_INVERT_DEPTH: invert_depth <= cfg_data[0];
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == P_STRIP && div_done) begin
      strip <= div_q[LW_W-1:0];
    end
    if (state == P_RECIP && div_done) begin
      recip <= div_q[RECIP_W-1:0];
    end
  end

  always_comb begin
    prm.width  = eff_w;
    prm.strip  = strip;
    prm.recip  = recip;
    prm.invert = invert_depth;
    prm.ready  = (state == P_IDLE);
  end

endmodule
